// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked assertions with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define APC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_pkg
// shared types and constants of the piecewise-linear calibration block
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

	// register file
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_BP_ONE   = 2'd0,
		REG_BP_TWO   = 2'd1,
		REG_BP_THREE = 2'd2,
		REG_BP_FOUR  = 2'd3
	} apc_reg_t;

	// breakpoint reset values, cut to the sample width at the register
	localparam int BP_ONE_RESET   = 820;
	localparam int BP_TWO_RESET   = 1640;
	localparam int BP_THREE_RESET = 2460;
	localparam int BP_FOUR_RESET  = 3270;

	localparam int NUM_SEGMENTS = 5;
	localparam int SEG_W        = 3;

	// percent output
	localparam int              PCT_W   = 7;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// control that travels with each item down the chain
	typedef struct packed {
		logic             full;
		logic [SEG_W-1:0] seg;
	} apc_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/apc_if.sv -----
// ----------------------------------------------------------------------------
// apc_if
// valid/ready stream channels for samples and calibrated results
// ----------------------------------------------------------------------------
`default_nettype none

interface apc_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface apc_result_if #(
	parameter int FRAC_BITS = 10
);
	logic                          valid;
	logic                          ready;
	logic [FRAC_BITS+2:0]          voltage_fixed;
	logic [apc_pkg::PCT_W-1:0]     percent_full_scale;

	modport source (output valid, output voltage_fixed, output percent_full_scale,
		input ready);
	modport sink (input valid, input voltage_fixed, input percent_full_scale,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/adc_piecewise_linear_calibration.sv -----
// ----------------------------------------------------------------------------
// adc_piecewise_linear_calibration
// five-segment piecewise-linear mapping of a converter sample to a voltage
// ----------------------------------------------------------------------------
//
// channel    role     handshake              payload
// sample     sink     valid / ready          adc_sample
// result     source   valid / ready          voltage_fixed, percent_full_scale
// apb        slave    psel/penable/pready    paddr, pwdata, prdata (breakpoints)
//
// one sample per cycle while the result channel is ready; the pipeline is the
// row of division cells (one quotient bit per cell) plus two setup stages and
// the result register
// every stage has its own valid and ready, so bubbles close up under a stall
// arst_n clears all valids and loads the breakpoint defaults
// breakpoints are read by the first stage only
//
`default_nettype none

module adc_piecewise_linear_calibration #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	apc_sample_if.sink                         sample,
	apc_result_if.source                       result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [apc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [apc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [apc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import apc_pkg::*;

	// breakpoint registers
	logic [SAMPLE_BITS-1:0] bp_one_q;
	logic [SAMPLE_BITS-1:0] bp_two_q;
	logic [SAMPLE_BITS-1:0] bp_three_q;
	logic [SAMPLE_BITS-1:0] bp_four_q;

	logic                   apb_wr;
	apc_reg_t               reg_sel;
	logic [SAMPLE_BITS-1:0] rd_val;

	// links of the chain: link i feeds cell i, link FRAC_BITS feeds the output
	logic                   vld_c [0:FRAC_BITS];
	logic                   rdy_c [0:FRAC_BITS];
	apc_ctl_t               ctl_c [0:FRAC_BITS];
	logic [SAMPLE_BITS-1:0] rem_c [0:FRAC_BITS];
	logic [SAMPLE_BITS-1:0] den_c [0:FRAC_BITS];
	logic [FRAC_BITS:0]     quo_c [0:FRAC_BITS];

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	// word index, byte lane bits are not decoded
	assign reg_sel = apc_reg_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_one_q   <= SAMPLE_BITS'(BP_ONE_RESET);
			bp_two_q   <= SAMPLE_BITS'(BP_TWO_RESET);
			bp_three_q <= SAMPLE_BITS'(BP_THREE_RESET);
			bp_four_q  <= SAMPLE_BITS'(BP_FOUR_RESET);
		end else if (apb_wr) begin
			case (reg_sel)
				REG_BP_ONE:   bp_one_q   <= pwdata[SAMPLE_BITS-1:0];
				REG_BP_TWO:   bp_two_q   <= pwdata[SAMPLE_BITS-1:0];
				REG_BP_THREE: bp_three_q <= pwdata[SAMPLE_BITS-1:0];
				REG_BP_FOUR:  bp_four_q  <= pwdata[SAMPLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BP_ONE:   rd_val = bp_one_q;
			REG_BP_TWO:   rd_val = bp_two_q;
			REG_BP_THREE: rd_val = bp_three_q;
			REG_BP_FOUR:  rd_val = bp_four_q;
			default:      rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DATA_W-SAMPLE_BITS){1'b0}}, rd_val};

	// ---------------------------------------------------------------- front end
	// segment search, then numerator / divisor and the top quotient bit
	apc_seg #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_sample (sample.adc_sample),
		.bp_one    (bp_one_q),
		.bp_two    (bp_two_q),
		.bp_three  (bp_three_q),
		.bp_four   (bp_four_q),
		.out_valid (vld_c[0]),
		.out_ready (rdy_c[0]),
		.out_ctl   (ctl_c[0]),
		.out_rem   (rem_c[0]),
		.out_den   (den_c[0]),
		.out_quo   (quo_c[0])
	);

	// ---------------------------------------------------------------- cell row
	// each cell resolves one fraction bit and hands the remainder on
	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
		apc_div_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.FRAC_BITS   (FRAC_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[i]),
			.in_ready  (rdy_c[i]),
			.in_ctl    (ctl_c[i]),
			.in_rem    (rem_c[i]),
			.in_den    (den_c[i]),
			.in_quo    (quo_c[i]),
			.out_valid (vld_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.out_ctl   (ctl_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_den   (den_c[i+1]),
			.out_quo   (quo_c[i+1])
		);
	end

	// ---------------------------------------------------------------- result
	// the final remainder and divisor are dropped here
	apc_out #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_c[FRAC_BITS]),
		.in_ready    (rdy_c[FRAC_BITS]),
		.in_ctl      (ctl_c[FRAC_BITS]),
		.in_quo      (quo_c[FRAC_BITS]),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_voltage (result.voltage_fixed),
		.out_percent (result.percent_full_scale)
	);

endmodule

`default_nettype wire

// ----- rtl/apc_seg.sv -----
// ----------------------------------------------------------------------------
// apc_seg
// segment search and divider setup: two pipeline stages ahead of the cell row
// ----------------------------------------------------------------------------
`default_nettype none

module apc_seg #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic [SAMPLE_BITS-1:0] bp_one,
	input  logic [SAMPLE_BITS-1:0] bp_two,
	input  logic [SAMPLE_BITS-1:0] bp_three,
	input  logic [SAMPLE_BITS-1:0] bp_four,
	output logic                   out_valid,
	input  logic                   out_ready,
	output apc_pkg::apc_ctl_t      out_ctl,
	output logic [SAMPLE_BITS-1:0] out_rem,
	output logic [SAMPLE_BITS-1:0] out_den,
	output logic [FRAC_BITS:0]     out_quo
);
	import apc_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	logic [SEG_W-1:0]       seg_d;
	logic [SAMPLE_BITS-1:0] lo_d;
	logic [SAMPLE_BITS-1:0] hi_d;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] lo_s1;
	logic [SAMPLE_BITS-1:0] hi_s1;
	apc_ctl_t               ctl_s1;

	logic                   span_ok;
	logic [SAMPLE_BITS-1:0] num_d;
	logic [SAMPLE_BITS-1:0] den_d;
	logic [SAMPLE_BITS-1:0] rem_d;
	logic [SAMPLE_BITS-1:0] den_sel;
	logic                   qtop_d;

	logic                   valid_s2;
	apc_ctl_t               ctl_s2;
	logic [SAMPLE_BITS-1:0] rem_s2;
	logic [SAMPLE_BITS-1:0] den_s2;
	logic                   qtop_s2;

	logic rdy_s1;
	logic rdy_s2;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// first segment whose upper breakpoint is not below the sample
	always_comb begin
		if (!(in_sample > bp_one)) begin
			seg_d = SEG_W'(0);
			lo_d  = '0;
			hi_d  = bp_one;
		end else if (!(in_sample > bp_two)) begin
			seg_d = SEG_W'(1);
			lo_d  = bp_one;
			hi_d  = bp_two;
		end else if (!(in_sample > bp_three)) begin
			seg_d = SEG_W'(2);
			lo_d  = bp_two;
			hi_d  = bp_three;
		end else if (!(in_sample > bp_four)) begin
			seg_d = SEG_W'(3);
			lo_d  = bp_three;
			hi_d  = bp_four;
		end else begin
			seg_d = SEG_W'(4);
			lo_d  = bp_four;
			hi_d  = SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sample_s1   <= in_sample;
			lo_s1       <= lo_d;
			hi_s1       <= hi_d;
			ctl_s1.seg  <= seg_d;
			ctl_s1.full <= (in_sample == SAMPLE_MAX);
		end
	end

	// top quotient bit here, so the remainder entering the cells is below den
	assign span_ok = (hi_s1 > lo_s1) && (sample_s1 > lo_s1);
	assign num_d   = sample_s1 - lo_s1;
	assign den_d   = hi_s1 - lo_s1;

	always_comb begin
		if (!span_ok) begin
			// empty or zero-width span: numerator zero over a unit divisor
			rem_d   = '0;
			den_sel = SAMPLE_BITS'(1);
			qtop_d  = 1'b0;
		end else if (num_d >= den_d) begin
			rem_d   = '0;
			den_sel = den_d;
			qtop_d  = 1'b1;
		end else begin
			rem_d   = num_d;
			den_sel = den_d;
			qtop_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			ctl_s2  <= ctl_s1;
			rem_s2  <= rem_d;
			den_s2  <= den_sel;
			qtop_s2 <= qtop_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_ctl   = ctl_s2;
	assign out_rem   = rem_s2;
	assign out_den   = den_s2;
	assign out_quo   = {{FRAC_BITS{1'b0}}, qtop_s2};

endmodule

`default_nettype wire

// ----- rtl/apc_div_cell.sv -----
// ----------------------------------------------------------------------------
// apc_div_cell
// one restoring-division step: one quotient bit per cell, registered
// ----------------------------------------------------------------------------
`default_nettype none

module apc_div_cell #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  apc_pkg::apc_ctl_t      in_ctl,
	input  logic [SAMPLE_BITS-1:0] in_rem,
	input  logic [SAMPLE_BITS-1:0] in_den,
	input  logic [FRAC_BITS:0]     in_quo,
	output logic                   out_valid,
	input  logic                   out_ready,
	output apc_pkg::apc_ctl_t      out_ctl,
	output logic [SAMPLE_BITS-1:0] out_rem,
	output logic [SAMPLE_BITS-1:0] out_den,
	output logic [FRAC_BITS:0]     out_quo
);
	import apc_pkg::*;

	logic [SAMPLE_BITS:0]   rem_x2;
	logic [SAMPLE_BITS:0]   rem_sub;
	logic                   bit_d;
	logic [SAMPLE_BITS-1:0] rem_d;

	logic                   valid_q;
	apc_ctl_t               ctl_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [FRAC_BITS:0]     quo_q;

	// remainder stays below den, so the difference fits the sample width
	assign rem_x2  = {in_rem, 1'b0};
	assign rem_sub = rem_x2 - {1'b0, in_den};
	assign bit_d   = (rem_x2 >= {1'b0, in_den});
	assign rem_d   = bit_d ? rem_sub[SAMPLE_BITS-1:0] : rem_x2[SAMPLE_BITS-1:0];

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_q <= in_ctl;
			rem_q <= rem_d;
			den_q <= in_den;
			quo_q <= {in_quo[FRAC_BITS-1:0], bit_d};
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_quo   = quo_q;

endmodule

`default_nettype wire

// ----- rtl/apc_out.sv -----
// ----------------------------------------------------------------------------
// apc_out
// voltage assembly, percent of full scale and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module apc_out #(
	parameter int FRAC_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  apc_pkg::apc_ctl_t            in_ctl,
	input  logic [FRAC_BITS:0]           in_quo,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [FRAC_BITS+2:0]         out_voltage,
	output logic [apc_pkg::PCT_W-1:0]    out_percent
);
	import apc_pkg::*;

	localparam int               VB        = FRAC_BITS + 3;
	localparam int               WB        = VB + 4;
	localparam logic [VB-1:0]    VOLT_FULL = VB'(NUM_SEGMENTS) << FRAC_BITS;

	logic [VB-1:0]    volt_d;
	logic [WB-1:0]    volt_x20;
	logic [PCT_W-1:0] pct_raw;
	logic [PCT_W-1:0] pct_d;

	logic             valid_q;
	logic [VB-1:0]    volt_q;
	logic [PCT_W-1:0] pct_q;

	assign volt_d = in_ctl.full ? VOLT_FULL
		: ({in_ctl.seg, {FRAC_BITS{1'b0}}} + {2'b00, in_quo});

	// 20 * v as 16v + 4v
	assign volt_x20 = ({4'b0000, volt_d} << 4) + ({4'b0000, volt_d} << 2);
	assign pct_raw  = volt_x20[WB-1:FRAC_BITS];
	assign pct_d    = (pct_raw > PCT_MAX) ? PCT_MAX : pct_raw;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			volt_q <= volt_d;
			pct_q  <= pct_d;
		end
	end

	assign out_valid   = valid_q;
	assign out_voltage = volt_q;
	assign out_percent = pct_q;

endmodule

`default_nettype wire

// ----- rtl/apc_checker.sv -----
// ----------------------------------------------------------------------------
// apc_checker
// port-level checks on the calibration block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module apc_checker #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 10
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [FRAC_BITS+2:0]             voltage_fixed,
	input logic [apc_pkg::PCT_W-1:0]        percent_full_scale,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic                             pready,
	input logic [apc_pkg::APB_ADDR_W-1:0]   paddr,
	input logic [apc_pkg::APB_DATA_W-1:0]   pwdata,
	input logic [apc_pkg::APB_DATA_W-1:0]   prdata
);
	import apc_pkg::*;

	localparam int WB = FRAC_BITS + 7;

	logic [WB-1:0]           pct_wide;
	logic [PCT_W-1:0]        pct_exp;
	logic                    wr_hit_q;
	logic [APB_ADDR_W-1:0]   wr_addr_q;
	logic [APB_DATA_W-1:0]   wr_val_q;
	logic                    rd_after_wr;
	logic                    in_seen;

	assign pct_wide = ({4'b0000, voltage_fixed} << 4) + ({4'b0000, voltage_fixed} << 2);
	assign pct_exp  = pct_wide[WB-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_hit_q <= 1'b0;
		end else begin
			wr_hit_q <= psel && penable && pwrite && pready;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= paddr;
		wr_val_q  <= {{(APB_DATA_W-SAMPLE_BITS){1'b0}}, pwdata[SAMPLE_BITS-1:0]};
	end

	assign rd_after_wr = wr_hit_q && psel && !pwrite && (paddr == wr_addr_q);
	assign in_seen     = in_valid || !in_valid;

	// a held result keeps its value
	`APC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(voltage_fixed), "result changed while stalled")

	// percent agrees with the voltage in the same transfer
	`APC_ASSERT_NOW(a_pct, clk, arst_n, out_valid, percent_full_scale == pct_exp, "percent does not match voltage")

	// with the output side empty the whole row is free to take a sample
	`APC_ASSERT_NOW(a_drain, clk, arst_n, !out_valid && in_seen, in_ready, "input stalled with empty output")

	// a breakpoint reads back what was written just before
	`APC_ASSERT_NOW(a_rdbk, clk, arst_n, rd_after_wr, prdata == wr_val_q, "breakpoint readback mismatch")

endmodule

bind adc_piecewise_linear_calibration apc_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.FRAC_BITS   (FRAC_BITS)
) u_apc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (sample.valid),
	.in_ready           (sample.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.voltage_fixed      (result.voltage_fixed),
	.percent_full_scale (result.percent_full_scale),
	.psel               (psel),
	.penable            (penable),
	.pwrite             (pwrite),
	.pready             (pready),
	.paddr              (paddr),
	.pwdata             (pwdata),
	.prdata             (prdata)
);

`default_nettype wire
